// File: design/dollar_decimal_escape_codec_top_macros.svh
// ----------------------------------------------------------------------------
// dollar_decimal_escape_codec_top_macros
// Assertion helpers for the codec; checks sample on the rising edge of clk.
// ----------------------------------------------------------------------------
`ifndef DOLLAR_DECIMAL_ESCAPE_CODEC_TOP_MACROS_SVH
`define DOLLAR_DECIMAL_ESCAPE_CODEC_TOP_MACROS_SVH

// Check that is switched off while reset is held.
`define DDE_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that also holds during reset.
`define DDE_CHECK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/dde_pkg.sv
// ----------------------------------------------------------------------------
// dde_pkg
// Types and constants shared by the dollar-decimal escape codec.
// ----------------------------------------------------------------------------
package dde_pkg;

  localparam int unsigned MAX_RES = 4;
  localparam int unsigned CNT_W   = $clog2(MAX_RES + 1);
  localparam int unsigned IDX_W   = $clog2(MAX_RES);

  localparam logic [7:0] DOLLAR      = 8'h24;
  localparam logic [7:0] ZERO_CHAR   = 8'h30;
  localparam logic [7:0] PLAIN_LIMIT = 8'h7F;
  localparam logic [7:0] DQUOTE      = 8'h22;
  localparam logic [7:0] SQUOTE      = 8'h27;
  localparam logic [7:0] BACKSLASH   = 8'h5C;
  localparam logic [7:0] SLASH       = 8'h2F;

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_DOLLAR = 2'd1,
    PH_DIGIT1 = 2'd2,
    PH_DIGIT2 = 2'd3
  } phase_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       out_last;
  } out_t;

  typedef struct packed {
    out_t [MAX_RES-1:0] ent;
    logic [CNT_W-1:0]   cnt;
  } res_t;

endpackage

// File: design/dde_xlate.sv
// ----------------------------------------------------------------------------
// dde_xlate
// Translates one request into its set of result entries and the next
// escape state, for either direction.
// ----------------------------------------------------------------------------
module dde_xlate import dde_pkg::*; (
  input  logic       mode_i,
  input  phase_t     phase_i,
  input  logic [7:0] partial_i,
  input  in_t        item_i,
  output res_t       res_o,
  output phase_t     phase_o,
  output logic [7:0] partial_o
);

  logic [7:0]       b;
  logic [7:0]       d;
  logic [1:0]       hund;
  logic [6:0]       rem;
  logic [14:0]      tens_prod;
  logic [3:0]       tens;
  logic [3:0]       ones;
  logic             plain;
  logic [IDX_W-1:0] last_idx;
  logic [CNT_W-1:0] cnt_dec;

  function automatic out_t mk(input logic [7:0] v);
    mk = '{out_byte: v, out_valid: 1'b1, out_last: 1'b0};
  endfunction

  // Split the byte into decimal digits
  always_comb begin
    b = item_i.in_byte;
    d = b - ZERO_CHAR;
    if (b >= 8'd200) begin
      hund = 2'd2;
      rem  = 7'(b - 8'd200);
    end else if (b >= 8'd100) begin
      hund = 2'd1;
      rem  = 7'(b - 8'd100);
    end else begin
      hund = 2'd0;
      rem  = b[6:0];
    end
    // floor(rem / 10) by reciprocal, exact for rem below 100
    tens_prod = 15'(rem) * 15'd205;
    tens      = tens_prod[14:11];
    ones      = 4'(rem - 7'(tens) * 7'd10);
    plain     = (b < PLAIN_LIMIT) && (b != DQUOTE) && (b != SQUOTE) &&
                (b != BACKSLASH) && (b != SLASH);
  end

  // Build the result set and next state
  always_comb begin
    res_o     = '0;
    phase_o   = phase_i;
    partial_o = partial_i;
    if (mode_i == MODE_ENCODE) begin
      phase_o   = PH_IDLE;
      partial_o = '0;
      if (b == DOLLAR) begin
        res_o.ent[0] = mk(DOLLAR);
        res_o.ent[1] = mk(DOLLAR);
        res_o.cnt    = CNT_W'(2);
      end else if (plain) begin
        res_o.ent[0] = mk(b);
        res_o.cnt    = CNT_W'(1);
      end else begin
        res_o.ent[0] = mk(DOLLAR);
        res_o.ent[1] = mk(ZERO_CHAR + {6'b0, hund});
        res_o.ent[2] = mk(ZERO_CHAR + {4'b0, tens});
        res_o.ent[3] = mk(ZERO_CHAR + {4'b0, ones});
        res_o.cnt    = CNT_W'(4);
      end
    end else begin
      unique case (phase_i)
        PH_IDLE: begin
          if (b == DOLLAR) begin
            phase_o = PH_DOLLAR;
          end else begin
            res_o.ent[0] = mk(b);
            res_o.cnt    = CNT_W'(1);
          end
        end
        PH_DOLLAR: begin
          if (b == DOLLAR) begin
            res_o.ent[0] = mk(DOLLAR);
            res_o.cnt    = CNT_W'(1);
            phase_o      = PH_IDLE;
          end else begin
            partial_o = 8'(d * 8'd100);
            phase_o   = PH_DIGIT1;
          end
        end
        PH_DIGIT1: begin
          partial_o = partial_i + 8'(d * 8'd10);
          phase_o   = PH_DIGIT2;
        end
        PH_DIGIT2: begin
          res_o.ent[0] = mk(partial_i + d);
          res_o.cnt    = CNT_W'(1);
          partial_o    = '0;
          phase_o      = PH_IDLE;
        end
        default: begin
          phase_o = PH_IDLE;
        end
      endcase
    end

    // Close the string: flag the final entry or add an empty marker
    cnt_dec  = res_o.cnt - CNT_W'(1);
    last_idx = cnt_dec[IDX_W-1:0];
    if (item_i.in_last) begin
      phase_o   = PH_IDLE;
      partial_o = '0;
      if (res_o.cnt == '0) begin
        res_o.ent[0] = '{out_byte: 8'h00, out_valid: 1'b0, out_last: 1'b1};
        res_o.cnt    = CNT_W'(1);
      end else begin
        res_o.ent[last_idx].out_last = 1'b1;
      end
    end
  end

endmodule

// File: design/dde_serial.sv
// ----------------------------------------------------------------------------
// dde_serial
// Result buffer: holds one request's entries, hands them out one per cycle
// while out_ready is high and takes the next set as the final entry leaves.
// ----------------------------------------------------------------------------
module dde_serial import dde_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic load_i,
  input  res_t res_i,
  output logic free_o,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  out_t [MAX_RES-1:0] ent_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [IDX_W-1:0]   idx_r;
  logic [CNT_W-1:0]   cnt_dec;
  logic               take;
  logic               final_take;

  assign cnt_dec    = cnt_r - CNT_W'(1);
  assign out_valid  = (cnt_r != '0);
  assign out_data   = ent_r[idx_r];
  assign take       = out_valid && out_ready;
  assign final_take = take && (idx_r == cnt_dec[IDX_W-1:0]);
  assign free_o     = !out_valid || final_take;

  // Advance through the held entries, reload on a new request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      idx_r <= '0;
    end else if (load_i) begin
      cnt_r <= res_i.cnt;
      idx_r <= '0;
    end else if (final_take) begin
      cnt_r <= '0;
      idx_r <= '0;
    end else if (take) begin
      idx_r <= idx_r + IDX_W'(1);
    end
  end

  // Hold the entry payload
  always_ff @(posedge clk) begin
    if (load_i) begin
      ent_r <= res_i.ent;
    end
  end

endmodule

// File: design/dollar_decimal_escape_codec_top.sv
// ----------------------------------------------------------------------------
// dollar_decimal_escape_codec_top
// Dollar-decimal escape codec: encodes bytes into $-escapes or decodes them.
// ----------------------------------------------------------------------------
// A request is translated in the cycle it is accepted and its results go into
// a buffer of four entries that drains one result per cycle while out_ready is
// high. In encode mode a plain byte yields one result, '$' two and a decimal
// escape four; the next request is taken in the same cycle as the final result
// leaves. Decode requests inside an escape give no result and leave the buffer
// free. The mode register is written through the cfg port and is always ready.
module dollar_decimal_escape_codec_top import dde_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic cfg_data,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  `include "dollar_decimal_escape_codec_top_macros.svh"

  logic       mode_r;
  phase_t     phase_r;
  phase_t     phase_nxt;
  logic [7:0] partial_r;
  logic [7:0] partial_nxt;
  res_t       res;
  logic       accept;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;

  // Hold the mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_ENCODE;
    end else if (cfg_valid && cfg_ready) begin
      mode_r <= cfg_data;
    end
  end

  // Advance the escape state on each accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      partial_r <= '0;
    end else if (accept) begin
      phase_r   <= phase_nxt;
      partial_r <= partial_nxt;
    end
  end

  dde_xlate u_xlate (
    .mode_i    (mode_r),
    .phase_i   (phase_r),
    .partial_i (partial_r),
    .item_i    (in_data),
    .res_o     (res),
    .phase_o   (phase_nxt),
    .partial_o (partial_nxt)
  );

  dde_serial u_serial (
    .clk       (clk),
    .rst_n     (rst_n),
    .load_i    (accept),
    .res_i     (res),
    .free_o    (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Checks
  `DDE_CHECK(a_enc_idle, (accept && mode_r == MODE_ENCODE) |=> (phase_r == PH_IDLE && partial_r == 8'h00), "encode request left escape state set")
  `DDE_CHECK(a_last_clear, (accept && in_data.in_last) |=> (phase_r == PH_IDLE && partial_r == 8'h00), "end of string did not clear escape state")
  `DDE_CHECK(a_empty_last, (out_valid && !out_data.out_valid) |-> out_data.out_last, "empty result without end marker")
  `DDE_CHECK_ALWAYS(a_stall_block, (rst_n && out_valid && !out_ready) |-> !in_ready, "request taken while results stalled")

endmodule

// File: test/dollar_decimal_escape_codec_top_tb.sv
// ----------------------------------------------------------------------------
// dollar_decimal_escape_codec_top_tb
// Self-checking bench for the dollar-decimal escape codec. Strings of bytes
// are sent in encode and decode phases. Each accepted request is run through
// a local predictor of the codec, which queues the expected output bytes.
// Every output handshake is checked field by field against the oldest entry.
// Both ports idle at random, and the output side holds off once for a long
// stretch so that the codec fills up and stalls its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dollar_decimal_escape_codec_top_tb;
  import dde_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 320;
  localparam int FAIL_PRINTS  = 50;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_data  = 1'b0;
  logic in_valid  = 1'b0;
  in_t  in_data   = '0;
  logic out_ready = 1'b0;
  logic cfg_ready;
  logic in_ready;
  logic out_valid;
  out_t out_data;

  // Request source and expected output bytes
  in_t        pending_reqs[$];
  out_t       expected_bytes[$];
  logic [7:0] word_bytes[$];
  int         queued_total = 0;
  int         reqs_taken   = 0;
  int         fail_count   = 0;
  int         cycle_count  = 0;
  bit         steady       = 1'b0;

  // Handshakes seen at the last rising edge
  logic in_took  = 1'b0;
  logic cfg_took = 1'b0;

  // Predictor state
  logic       codec_mode = MODE_ENCODE;
  phase_t     esc_phase  = PH_IDLE;
  logic [7:0] esc_acc    = '0;

  // Driver and receiver pacing
  int  send_gap   = 0;
  int  stall_left = 0;
  int  hold_left  = 0;
  bit  hold_done  = 1'b0;

  dollar_decimal_escape_codec_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    fail_count++;
    if (fail_count <= FAIL_PRINTS) begin
      $display("mismatch at %0t ns: %s", $time, what);
    end
  endtask

  function automatic void push_byte(input logic [7:0] b, input logic v);
    out_t r;
    r.out_byte  = b;
    r.out_valid = v;
    r.out_last  = 1'b0;
    expected_bytes.push_back(r);
  endfunction

  function automatic logic passes_plain(input logic [7:0] b);
    return b < PLAIN_LIMIT && b != DQUOTE && b != SQUOTE && b != BACKSLASH && b != SLASH;
  endfunction

  // Work out the output bytes that one request causes
  function automatic void codec_step(input in_t req);
    logic [7:0] b;
    logic [7:0] d;
    int         n;
    out_t       tail;
    b = req.in_byte;
    d = b - ZERO_CHAR;
    n = 0;
    if (codec_mode == MODE_ENCODE) begin
      esc_phase = PH_IDLE;
      esc_acc   = '0;
      if (b == DOLLAR) begin
        push_byte(DOLLAR, 1'b1);
        push_byte(DOLLAR, 1'b1);
        n = 2;
      end else if (passes_plain(b)) begin
        push_byte(b, 1'b1);
        n = 1;
      end else begin
        push_byte(DOLLAR, 1'b1);
        push_byte(ZERO_CHAR + b / 8'd100, 1'b1);
        push_byte(ZERO_CHAR + (b / 8'd10) % 8'd10, 1'b1);
        push_byte(ZERO_CHAR + b % 8'd10, 1'b1);
        n = 4;
      end
    end else begin
      case (esc_phase)
        PH_IDLE: begin
          if (b == DOLLAR) begin
            esc_phase = PH_DOLLAR;
          end else begin
            push_byte(b, 1'b1);
            n = 1;
          end
        end
        PH_DOLLAR: begin
          if (b == DOLLAR) begin
            push_byte(DOLLAR, 1'b1);
            n = 1;
            esc_phase = PH_IDLE;
          end else begin
            esc_acc   = 8'd100 * d;
            esc_phase = PH_DIGIT1;
          end
        end
        PH_DIGIT1: begin
          esc_acc   = esc_acc + 8'd10 * d;
          esc_phase = PH_DIGIT2;
        end
        default: begin
          push_byte(esc_acc + d, 1'b1);
          n = 1;
          esc_acc   = '0;
          esc_phase = PH_IDLE;
        end
      endcase
    end
    // End of string: drop any pending escape and mark the final output
    if (req.in_last) begin
      esc_phase = PH_IDLE;
      esc_acc   = '0;
      if (n == 0) begin
        push_byte(8'h00, 1'b0);
      end
      tail = expected_bytes.pop_back();
      tail.out_last = 1'b1;
      expected_bytes.push_back(tail);
    end
  endfunction

  // Sample both handshakes, advance the predictor and check outputs
  always @(posedge clk) begin : monitor
    out_t want;
    in_took  <= in_valid && in_ready;
    cfg_took <= cfg_valid && cfg_ready;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        codec_mode = cfg_data;
      end
      if (in_valid && in_ready) begin
        codec_step(in_data);
        reqs_taken++;
      end
      if (out_valid && out_ready) begin
        if (expected_bytes.size() == 0) begin
          report_mismatch($sformatf("unexpected output %h", out_data));
        end else begin
          want = expected_bytes.pop_front();
          if (out_data.out_byte !== want.out_byte)
            report_mismatch($sformatf("out_byte %h, want %h", out_data.out_byte,
                                      want.out_byte));
          if (out_data.out_valid !== want.out_valid)
            report_mismatch($sformatf("out_valid %b, want %b", out_data.out_valid,
                                      want.out_valid));
          if (out_data.out_last !== want.out_last)
            report_mismatch($sformatf("out_last %b, want %b", out_data.out_last,
                                      want.out_last));
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 70) return 0;
    if (r < 96) return $urandom_range(1, 3);
    return $urandom_range(12, 40);
  endfunction

  // Offer queued requests; hold each one until it is taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_took) begin
      // hold the current request
    end else if (send_gap > 0) begin
      in_valid <= 1'b0;
      send_gap <= send_gap - 1;
    end else if (pending_reqs.size() > 0) begin
      in_valid <= 1'b1;
      in_data  <= pending_reqs.pop_front();
      send_gap <= pick_gap();
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Output side: random stalls, plus one long hold-off while requests keep coming
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && reqs_taken >= 60) begin
      out_ready <= 1'b0;
      hold_done <= 1'b1;
      hold_left <= 300;
    end else if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready  <= 1'b1;
      stall_left <= pick_gap();
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic push_req(input logic [7:0] b, input logic last);
    in_t r;
    r.in_byte = b;
    r.in_last = last;
    pending_reqs.push_back(r);
    queued_total++;
  endtask

  task automatic flush_word();
    foreach (word_bytes[i]) push_req(word_bytes[i], i == word_bytes.size() - 1);
    word_bytes.delete();
  endtask

  // Wait until the codec is idle, with margin for requests that give no output
  task automatic settle();
    @(negedge clk);
    while (pending_reqs.size() != 0 || in_valid || expected_bytes.size() != 0)
      @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_mode(input logic m);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    @(negedge clk);
    while (!cfg_took) @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] encode_pick();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 8'($urandom_range(0, 255));
    if (r < 55) return DOLLAR;
    if (r < 75) begin
      case ($urandom_range(0, 3))
        0:       return DQUOTE;
        1:       return SQUOTE;
        2:       return BACKSLASH;
        default: return SLASH;
      endcase
    end
    if (r < 85) return PLAIN_LIMIT + 8'($urandom_range(0, 2)) - 8'd1;
    return 8'($urandom_range(8'h20, 8'h7E));
  endfunction

  function automatic logic [7:0] plain_pick();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    return (b == DOLLAR) ? 8'h41 : b;
  endfunction

  task automatic build_encode_word();
    int len;
    len = $urandom_range(1, 10);
    repeat (len) word_bytes.push_back(encode_pick());
    flush_word();
  endtask

  // Mostly well-formed escapes with random content, some noise and cut-short tails
  task automatic build_decode_word();
    int tokens;
    int r;
    int k;
    tokens = $urandom_range(1, 6);
    repeat (tokens) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        word_bytes.push_back(plain_pick());
      end else if (r < 55) begin
        word_bytes.push_back(DOLLAR);
        word_bytes.push_back(DOLLAR);
      end else if (r < 85) begin
        word_bytes.push_back(DOLLAR);
        repeat (3) word_bytes.push_back(ZERO_CHAR + 8'($urandom_range(0, 9)));
      end else if (r < 95) begin
        word_bytes.push_back(DOLLAR);
        repeat (3) word_bytes.push_back(8'($urandom_range(0, 255)));
      end else begin
        word_bytes.push_back(8'($urandom_range(0, 255)));
      end
    end
    if ($urandom_range(0, 9) == 0) begin
      word_bytes.push_back(DOLLAR);
      k = $urandom_range(0, 2);
      repeat (k) word_bytes.push_back(ZERO_CHAR + 8'($urandom_range(0, 9)));
    end
    flush_word();
  endtask

  initial begin : stimulus
    int   start_total;
    int   quota;
    int   phase_no;
    logic mode_sel;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Encode extremes, '$', each quoting character and the plain limit
    write_mode(MODE_ENCODE);
    push_req(8'h00, 1'b0);
    push_req(8'hFF, 1'b0);
    push_req(DOLLAR, 1'b0);
    push_req(DQUOTE, 1'b0);
    push_req(SQUOTE, 1'b0);
    push_req(BACKSLASH, 1'b0);
    push_req(SLASH, 1'b0);
    push_req(PLAIN_LIMIT, 1'b0);
    push_req(8'h41, 1'b1);
    settle();

    // Decode a doubled '$', a wrapping escape and one with arbitrary bytes
    write_mode(MODE_DECODE);
    push_req(DOLLAR, 1'b0);
    push_req(DOLLAR, 1'b0);
    push_req(DOLLAR, 1'b0);
    push_req(8'h39, 1'b0);
    push_req(8'h39, 1'b0);
    push_req(8'h39, 1'b0);
    push_req(DOLLAR, 1'b0);
    push_req(8'hFF, 1'b0);
    push_req(8'h00, 1'b0);
    push_req(8'h80, 1'b1);
    settle();

    // Escape cut short by the end of the string: only an empty end marker
    push_req(DOLLAR, 1'b0);
    push_req(8'h31, 1'b1);
    settle();

    // Mode rewritten mid-escape: the escape carries on
    push_req(DOLLAR, 1'b0);
    push_req(8'h34, 1'b0);
    settle();
    write_mode(MODE_DECODE);
    push_req(8'h32, 1'b0);
    push_req(8'h30, 1'b1);
    settle();

    // Random phases, alternating direction; every fourth one without idling
    start_total = queued_total;
    mode_sel    = MODE_DECODE;
    phase_no    = 0;
    while (queued_total - start_total < RANDOM_ITEMS) begin
      settle();
      mode_sel = ~mode_sel;
      steady   = (phase_no % 4 == 3);
      write_mode(mode_sel);
      quota = queued_total + $urandom_range(25, 60);
      while (queued_total < quota) begin
        if (mode_sel == MODE_ENCODE) build_encode_word();
        else build_decode_word();
      end
      phase_no++;
    end

    settle();
    repeat (20) @(negedge clk);
    if (expected_bytes.size() != 0)
      report_mismatch($sformatf("%0d outputs never arrived", expected_bytes.size()));
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
